[rtl/core/wrdm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrdm_pkg: shared types and constants for the RMS decibel meter
// Sequencer states, register indexes, field widths and the fixed-point
// constants of the log2 and dB conversion.
// ----------------------------------------------------------------------------
package wrdm_pkg;

   // Field and register widths
   localparam int SAMPLE_W = 12;
   localparam int WLEN_W   = 9;
   localparam int DBOFF_W  = 15;
   localparam int RMS_W    = 16;
   localparam int LEVEL_W  = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 15;

   // Largest window; the effective length is clamped to it
   localparam logic [WLEN_W-1:0] MAX_WINDOW = 9'd256;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_CODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DB_OFFSET     = 2'd2;

   // Register reset values
   localparam logic [SAMPLE_W-1:0]       OFFSET_RESET = 12'd2048;
   localparam logic [WLEN_W-1:0]         WLEN_RESET   = 9'd200;
   localparam logic signed [DBOFF_W-1:0] DBOFF_RESET  = -15'sd480;

   // Iteration counts of the shared-unit loops
   localparam int DIV_STEPS  = 20;  // radix-4, 40 quotient bits
   localparam int SQRT_STEPS = 20;  // one result bit per step
   localparam int LOG_STEPS  = 24;  // fraction bits of log2

   // Accumulator, quotient and log widths
   localparam int SUM_W  = 32;
   localparam int DVD_W  = 40;      // square_sum * 256
   localparam int MANT_W = 31;      // Q1.30 mantissa
   localparam int LOG_W  = 28;      // log2 in Q24, integer part 0..15

   // 5120*log10(2) in Q20 and the rounding/offset bias of the dB scale
   localparam logic [63:0] LOG_K = 64'd1616142483;
   localparam logic [63:0] LEVEL_BIAS =
      (64'd1 << 57) - (LOG_K << 26) + (64'd1 << 43);
   localparam logic signed [21:0] LEVEL_SHIFT = 22'sd8192;

   // Level reported for a silent window (-100 dB in Q8.8)
   localparam logic signed [LEVEL_W-1:0] DB_FLOOR_Q8 = -16'sd25600;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_SQUARE,
      S_ACCUM,
      S_DIV,
      S_SQRT,
      S_NORM,
      S_LOG_INIT,
      S_LOG_MUL,
      S_LOG_STEP,
      S_LEVEL_MUL,
      S_LEVEL,
      S_FINISH
   } state_type;

endpackage

[rtl/core/windowed_rms_decibel_meter.sv]
`timescale 1ns / 1ps
// A sample that does not close a window passes through S_SQUARE and S_ACCUM
// before the input is ready again. A closing sample then runs 20 radix-4 divide
// steps, 20 root steps and 24 log steps (each a squaring on the one shared 32x32
// multiplier, then a bit decision); the log is skipped when the RMS is zero. After
// a closing sample the input waits until its result is in the output register.
// Reset (synchronous, active high) clears the window and any pending result.
// ----------------------------------------------------------------------------
// windowed_rms_decibel_meter: windowed RMS meter with dB readout
// Accumulates squared offset-removed ADC codes; at the end of each window it
// divides by the length, takes the integer root (Q12.4) and converts it to a
// Q8.8 dB level through an iterative log2 on a shared multiplier.
// ----------------------------------------------------------------------------
module windowed_rms_decibel_meter
   import wrdm_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   // sample channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [SAMPLE_W-1:0]          req_sample,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [RMS_W-1:0]             rsp_rms_q4,
   output logic signed [LEVEL_W-1:0]    rsp_level_db_q8,
   // configuration write port
   input  logic                         csr_write_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   // Control state
   state_type                   state_ff, state_in;
   logic [4:0]                  iter_ff, iter_in;
   logic [WLEN_W-1:0]           count_ff, count_in;
   logic [SUM_W-1:0]            sum_ff, sum_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // Configuration registers
   logic [SAMPLE_W-1:0]         offset_ff;
   logic [WLEN_W-1:0]           wlen_ff;
   logic signed [DBOFF_W-1:0]   dboff_ff;

   // Datapath registers
   logic [SAMPLE_W-1:0]         absd_ff, absd_in;
   logic [63:0]                 prod_ff, prod_in;
   logic [DVD_W-1:0]            dvd_ff, dvd_in;
   logic [7:0]                  rem_ff, rem_in;
   logic [WLEN_W-1:0]           n_ff, n_in;
   logic [DVD_W-1:0]            res_ff, res_in;
   logic [DVD_W-1:0]            bit_ff, bit_in;
   logic [RMS_W-1:0]            rms_ff, rms_in;
   logic [MANT_W-1:0]           m_ff, m_in;
   logic [LOG_W-1:0]            lr_ff, lr_in;
   logic [19:0]                 lvl_ff, lvl_in;
   logic [RMS_W-1:0]            out_rms_ff, out_rms_in;
   logic signed [LEVEL_W-1:0]   out_lvl_ff, out_lvl_in;

   // Shared multiplier operands
   logic [31:0]                 mul_a, mul_b;

   // Combinational helpers
   logic signed [SAMPLE_W:0]    diff;
   logic [SUM_W:0]              sum_wide;
   logic [SUM_W-1:0]            sum_sat;
   logic [WLEN_W-1:0]           n_eff;
   logic [8:0]                  r1, r2;
   logic                        q1, q2;
   logic [7:0]                  r1s;
   logic [DVD_W-1:0]            sq_trial;
   logic [3:0]                  msb;
   logic [31:0]                 mm;
   logic [63:0]                 level_u;
   logic signed [21:0]          level_v;

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rms_q4      = out_rms_ff;
   assign rsp_level_db_q8 = out_lvl_ff;

   // Effective window length: zero counts as one, clamp to the maximum
   always_comb begin
      if (wlen_ff == '0) begin
         n_eff = 9'd1;
      end else if (wlen_ff > MAX_WINDOW) begin
         n_eff = MAX_WINDOW;
      end else begin
         n_eff = wlen_ff;
      end
   end

   // Offset removal and magnitude of the incoming code
   assign diff = $signed({1'b0, req_sample}) - $signed({1'b0, offset_ff});

   // Saturating accumulate of the registered square
   assign sum_wide = {1'b0, sum_ff} + {9'b0, prod_ff[23:0]};
   assign sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

   // Two restoring divide steps per cycle against a divisor of up to 256
   always_comb begin
      r1  = {rem_ff, dvd_ff[DVD_W-1]};
      q1  = (r1 >= n_ff);
      r1s = q1 ? 8'(r1 - n_ff) : r1[7:0];
      r2  = {r1s, dvd_ff[DVD_W-2]};
      q2  = (r2 >= n_ff);
   end

   // Root trial value
   assign sq_trial = res_ff + bit_ff;

   // Position of the leading one of the RMS code
   always_comb begin
      msb = '0;
      for (int i = 0; i < RMS_W; i++) begin
         if (rms_ff[i]) begin
            msb = 4'(i);
         end
      end
   end

   // Squared mantissa back to Q1.30 (one spare bit above)
   assign mm = prod_ff[61:30];

   // dB scaling of log2 and final offset
   assign level_u = prod_ff + LEVEL_BIAS;
   assign level_v = $signed({2'b00, lvl_ff}) - LEVEL_SHIFT + 22'(dboff_ff);

   // Shared multiplier operand select
   always_comb begin
      case (state_ff)
         S_SQUARE: begin
            mul_a = {20'b0, absd_ff};
            mul_b = {20'b0, absd_ff};
         end
         S_LOG_MUL: begin
            mul_a = {1'b0, m_ff};
            mul_b = {1'b0, m_ff};
         end
         S_LEVEL_MUL: begin
            mul_a = {4'b0, lr_ff};
            mul_b = LOG_K[31:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      absd_in      = absd_ff;
      prod_in      = prod_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      n_in         = n_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      rms_in       = rms_ff;
      m_in         = m_ff;
      lr_in        = lr_ff;
      lvl_in       = lvl_ff;
      out_rms_in   = out_rms_ff;
      out_lvl_in   = out_lvl_ff;

      // result leaves on its transfer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               absd_in  = diff[SAMPLE_W] ? 12'(-diff) : diff[SAMPLE_W-1:0];
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            prod_in  = 64'(mul_a) * 64'(mul_b);
            state_in = S_ACCUM;
         end
         S_ACCUM: begin
            count_in = count_ff + 9'd1;
            if (count_in >= n_eff) begin
               // window closes: start the divide by N
               dvd_in   = {sum_sat, 8'b0};
               rem_in   = '0;
               n_in     = n_eff;
               sum_in   = '0;
               count_in = '0;
               iter_in  = '0;
               state_in = S_DIV;
            end else begin
               sum_in   = sum_sat;
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            dvd_in  = {dvd_ff[DVD_W-3:0], q1, q2};
            rem_in  = q2 ? 8'(r2 - n_ff) : r2[7:0];
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'(DIV_STEPS - 1)) begin
               res_in   = '0;
               bit_in   = 40'd1 << 38;
               iter_in  = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            // dvd_ff now holds the remaining radicand
            if (dvd_ff >= sq_trial) begin
               dvd_in = dvd_ff - sq_trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'(SQRT_STEPS - 1)) begin
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            rms_in   = (res_ff > 40'd65535) ? '1 : res_ff[RMS_W-1:0];
            state_in = S_LOG_INIT;
         end
         S_LOG_INIT: begin
            if (rms_ff == '0) begin
               state_in = S_FINISH;
            end else begin
               m_in     = MANT_W'({15'b0, rms_ff} << (5'd30 - {1'b0, msb}));
               lr_in    = {24'b0, msb};
               iter_in  = '0;
               state_in = S_LOG_MUL;
            end
         end
         S_LOG_MUL: begin
            prod_in  = 64'(mul_a) * 64'(mul_b);
            state_in = S_LOG_STEP;
         end
         S_LOG_STEP: begin
            // one fraction bit of log2 per squaring
            if (mm[31]) begin
               m_in  = mm[31:1];
               lr_in = {lr_ff[LOG_W-2:0], 1'b1};
            end else begin
               m_in  = mm[30:0];
               lr_in = {lr_ff[LOG_W-2:0], 1'b0};
            end
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'(LOG_STEPS - 1)) begin
               state_in = S_LEVEL_MUL;
            end else begin
               state_in = S_LOG_MUL;
            end
         end
         S_LEVEL_MUL: begin
            prod_in  = 64'(mul_a) * 64'(mul_b);
            state_in = S_LEVEL;
         end
         S_LEVEL: begin
            lvl_in   = level_u[63:44];
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               out_rms_in = rms_ff;
               if (rms_ff == '0) begin
                  out_lvl_in = DB_FLOOR_Q8;
               end else if (level_v > 22'sd32767) begin
                  out_lvl_in = 16'sh7FFF;
               end else if (level_v < -22'sd32768) begin
                  out_lvl_in = -16'sh8000;
               end else begin
                  out_lvl_in = level_v[LEVEL_W-1:0];
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iter_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration registers; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
         wlen_ff   <= WLEN_RESET;
         dboff_ff  <= DBOFF_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_OFFSET_CODE:   offset_ff <= csr_wdata[SAMPLE_W-1:0];
            REG_WINDOW_LENGTH: wlen_ff   <= csr_wdata[WLEN_W-1:0];
            REG_DB_OFFSET:     dboff_ff  <= $signed(csr_wdata[DBOFF_W-1:0]);
            default: ;
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      absd_ff    <= absd_in;
      prod_ff    <= prod_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      n_ff       <= n_in;
      res_ff     <= res_in;
      bit_ff     <= bit_in;
      rms_ff     <= rms_in;
      m_ff       <= m_in;
      lr_ff      <= lr_in;
      lvl_ff     <= lvl_in;
      out_rms_ff <= out_rms_in;
      out_lvl_ff <= out_lvl_in;
   end

endmodule
